// File: rtl/plti_pkg.sv
// shared codes, widths and controller/datapath handshake types for the table interpolator
package plti_pkg;

  localparam int KIND_W    = 2;
  localparam int SLOT_W    = 6;
  localparam int KCNT_W    = 7;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_EVAL = 2'd1,
    KIND_INV  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KNOT_COUNT = 1'b0,
    CFG_MISS_VALUE = 1'b1
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic prep;
    logic div_start;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic need_div;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/plti_item_if.sv
// input channel: one load, evaluate or inverse word
interface plti_item_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                              valid;
  logic                              ready;
  logic [plti_pkg::KIND_W-1:0]       kind;
  logic [plti_pkg::SLOT_W-1:0]       slot;
  logic signed [VALUE_WIDTH-1:0]     arg;
  logic signed [VALUE_WIDTH-1:0]     knot_y;

  modport source (output valid, kind, slot, arg, knot_y, input ready);
  modport sink (input valid, kind, slot, arg, knot_y, output ready);
endinterface

// File: rtl/plti_result_if.sv
// output channel: one result word per accepted input word
interface plti_result_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          hit;

  modport source (output valid, value, hit, input ready);
  modport sink (input valid, value, hit, output ready);
endinterface

// File: rtl/plti_muldiv.sv
// iterative floor(mag*t/den) for t < den, one bit of mag per cycle
module plti_muldiv #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W:0]   mag_i,
  input  logic [W-1:0] t_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W:0]   quot_o
);

  localparam int QW = W + 1;
  localparam int RW = W + 2;
  localparam int CW = $clog2(W + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [QW-1:0] m_q;
  logic [W-1:0]  t_q;
  logic [W-1:0]  den_q;
  logic [W-1:0]  r_q;
  logic [QW-1:0] q_q;

  logic [RW-1:0] r_sh;
  logic [RW-1:0] den1;
  logic [RW-1:0] den2;
  logic [RW-1:0] r_nx;
  logic [1:0]    dig;
  logic [RW-1:0] q_nx;

  // horner step: r' = 2r + bit*t stays below 3*den, so the digit is 0, 1 or 2
  always_comb begin
    r_sh = RW'({r_q, 1'b0}) + (m_q[QW-1] ? RW'(t_q) : '0);
    den1 = RW'(den_q);
    den2 = {den1[RW-2:0], 1'b0};
    if (r_sh >= den2) begin
      r_nx = r_sh - den2;
      dig  = 2'd2;
    end else if (r_sh >= den1) begin
      r_nx = r_sh - den1;
      dig  = 2'd1;
    end else begin
      r_nx = r_sh;
      dig  = 2'd0;
    end
    q_nx = RW'({q_q, 1'b0}) + RW'(dig);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(W);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q   <= mag_i;
      t_q   <= t_i;
      den_q <= den_i;
      r_q   <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      m_q <= {m_q[QW-2:0], 1'b0};
      r_q <= W'(r_nx);
      q_q <= QW'(q_nx);
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = q_q;

endmodule

// File: rtl/plti_ctrl.sv
// sequencer: accept, scan, slope product, result hand-off
module plti_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output plti_pkg::cmd_t cmd_o,
  input  plti_pkg::sts_t sts_i
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_PREP   = 6'b000100,
    ST_DSTART = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_FIN    = 6'b100000
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = sts_i.need_div ? ST_PREP : ST_FIN;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DSTART;
      end
      ST_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/plti_dp.sv
// datapath: config registers, knot memories, segment scan, slope product, output register
module plti_dp #(
  parameter int MAX_KNOTS   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [plti_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [VALUE_WIDTH-1:0]            cfg_wdata_i,
  input  logic [plti_pkg::KIND_W-1:0]       kind_i,
  input  logic [plti_pkg::SLOT_W-1:0]       slot_i,
  input  logic signed [VALUE_WIDTH-1:0]     arg_i,
  input  logic signed [VALUE_WIDTH-1:0]     knot_y_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [VALUE_WIDTH-1:0]     out_value_o,
  output logic                              out_hit_o,
  input  plti_pkg::cmd_t                    cmd_i,
  output plti_pkg::sts_t                    sts_o
);

  localparam int W  = VALUE_WIDTH;
  localparam int AW = $clog2(MAX_KNOTS);
  localparam int NW = $clog2(MAX_KNOTS + 1);

  // configuration
  logic [plti_pkg::KCNT_W-1:0] knot_count_q;
  logic signed [W-1:0]         default_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_count_q <= '0;
      default_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        plti_pkg::CFG_KNOT_COUNT: knot_count_q <= cfg_wdata_i[plti_pkg::KCNT_W-1:0];
        plti_pkg::CFG_MISS_VALUE: default_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // accepted word
  plti_pkg::kind_e     kind_in;
  logic                scan_in;
  logic [NW-1:0]       n_sat;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;

  plti_pkg::kind_e     kind_q;
  logic signed [W-1:0] arg_q;
  logic [NW-1:0]       n_q;

  assign kind_in = plti_pkg::kind_e'(kind_i);
  assign scan_in = (kind_in == plti_pkg::KIND_EVAL) || (kind_in == plti_pkg::KIND_INV);
  assign n_sat   = (int'(knot_count_q) > MAX_KNOTS) ? NW'(MAX_KNOTS) : NW'(knot_count_q);
  assign wr_en   = cmd_i.accept && (kind_in == plti_pkg::KIND_LOAD) &&
                   (int'(slot_i) < MAX_KNOTS);
  assign wr_addr = AW'(slot_i);

  // knot memories, registered read
  logic [W-1:0]  mem_x [MAX_KNOTS];
  logic [W-1:0]  mem_y [MAX_KNOTS];
  logic [NW-1:0] issue_cnt_q;
  logic          issuing_q;
  logic          rd_vld_q;
  logic [NW-1:0] rd_idx_q;
  logic signed [W-1:0] rd_x_q;
  logic signed [W-1:0] rd_y_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[wr_addr] <= arg_i;
      mem_y[wr_addr] <= knot_y_i;
    end
    rd_x_q <= mem_x[issue_cnt_q[AW-1:0]];
    rd_y_q <= mem_y[issue_cnt_q[AW-1:0]];
  end

  // scan state
  logic signed [W-1:0] prev_x_q;
  logic signed [W-1:0] prev_y_q;
  logic signed [W-1:0] first_x_q;
  logic signed [W-1:0] last_x_q;
  logic signed [W-1:0] seg_x0_q;
  logic signed [W-1:0] seg_x1_q;
  logic signed [W-1:0] seg_y0_q;
  logic signed [W-1:0] seg_y1_q;
  logic                found_q;

  logic signed [W-1:0] key_prev;
  logic signed [W-1:0] key_cur;
  logic                seg_match;
  logic [NW-1:0]       n_last;

  assign key_prev  = (kind_q == plti_pkg::KIND_INV) ? prev_y_q : prev_x_q;
  assign key_cur   = (kind_q == plti_pkg::KIND_INV) ? rd_y_q : rd_x_q;
  assign seg_match = rd_vld_q && (rd_idx_q != '0) && !found_q &&
                     (key_prev <= arg_q) && (key_cur > arg_q);
  assign n_last    = n_q - NW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q   <= 1'b0;
      issue_cnt_q <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      found_q     <= 1'b0;
      n_q         <= '0;
      kind_q      <= plti_pkg::KIND_NONE;
    end else begin
      rd_vld_q <= issuing_q;
      rd_idx_q <= issue_cnt_q;
      if (cmd_i.accept) begin
        kind_q      <= kind_in;
        n_q         <= n_sat;
        issue_cnt_q <= '0;
        issuing_q   <= scan_in && (n_sat != '0);
        found_q     <= 1'b0;
      end else begin
        if (issuing_q) begin
          issue_cnt_q <= issue_cnt_q + NW'(1);
          if (issue_cnt_q == n_last) begin
            issuing_q <= 1'b0;
          end
        end
        if (seg_match) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      arg_q <= arg_i;
    end
    if (rd_vld_q) begin
      prev_x_q <= rd_x_q;
      prev_y_q <= rd_y_q;
      if (rd_idx_q == '0) begin
        first_x_q <= rd_x_q;
      end
      if (rd_idx_q == n_last) begin
        last_x_q <= rd_x_q;
      end
      if (seg_match) begin
        seg_x0_q <= prev_x_q;
        seg_x1_q <= rd_x_q;
        seg_y0_q <= prev_y_q;
        seg_y1_q <= rd_y_q;
      end
    end
  end

  // evaluate hit: a segment matched and x lies within the outer knots
  logic eval_hit;
  assign eval_hit = found_q && (n_q != '0) && (arg_q >= first_x_q) && (arg_q <= last_x_q);

  // slope operands
  logic [W:0]   dy_q;
  logic [W-1:0] den_q;
  logic [W-1:0] t_q;
  logic [W:0]   mag;
  logic [W:0]   quot;
  logic         div_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      dy_q  <= {seg_y1_q[W-1], seg_y1_q} - {seg_y0_q[W-1], seg_y0_q};
      den_q <= W'(seg_x1_q - seg_x0_q);
      t_q   <= W'(arg_q - seg_x0_q);
    end
  end

  assign mag = dy_q[W] ? (~dy_q + (W+1)'(1)) : dy_q;

  plti_muldiv #(
    .W (W)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .mag_i   (mag),
    .t_i     (t_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // result select
  logic [W-1:0] res_value;
  logic         res_hit;

  always_comb begin
    res_value = '0;
    res_hit   = 1'b0;
    case (kind_q) inside
      plti_pkg::KIND_EVAL: begin
        if (eval_hit) begin
          res_value = dy_q[W] ? (seg_y0_q - W'(quot)) : (seg_y0_q + W'(quot));
          res_hit   = 1'b1;
        end else begin
          res_value = default_q;
        end
      end
      plti_pkg::KIND_INV: begin
        if (n_q != '0) begin
          if (found_q) begin
            res_value = seg_x0_q;
            res_hit   = 1'b1;
          end else begin
            res_value = last_x_q;
          end
        end
      end
      plti_pkg::KIND_LOAD, plti_pkg::KIND_NONE: begin
        res_value = '0;
      end
      default: begin
        res_value = '0;
      end
    endcase
  end

  // output register
  logic                out_valid_q;
  logic signed [W-1:0] out_value_q;
  logic                out_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_value_q <= res_value;
      out_hit_q   <= res_hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_hit_o   = out_hit_q;

  assign sts_o.scan_done = !issuing_q && !rd_vld_q;
  assign sts_o.need_div  = (kind_q == plti_pkg::KIND_EVAL) && eval_hit;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// File: rtl/piecewise_linear_table_interp_top.sv
// top level of the piecewise linear table interpolator
//
// holds up to MAX_KNOTS (x, y) knots in signed fixed point (Q16.16 at the default
// width) and answers one word at a time. a load word writes one knot and returns
// value 0, hit 0. an evaluate word scans the knots in use for the first segment
// with x_i <= x < x_i+1 and returns y_i + (y_i+1 - y_i) * (x - x_i) / (x_i+1 - x_i),
// quotient truncated toward zero; an empty table, x outside the outer knots, or no
// matching segment returns the miss value register with hit 0. an inverse word
// returns x_i of the first segment with y_i <= y < y_i+1, else the last knot's x
// with hit 0, and 0 with hit 0 on an empty table. knot_count above MAX_KNOTS counts
// as MAX_KNOTS; a load to a slot at or above MAX_KNOTS writes nothing. knots read
// before they are loaded give unspecified results.
// one word is in flight at a time. a load, an unknown word, or a query on an
// empty table passes from accept through the scan and finish states to the output
// register. evaluate and inverse stream the knot memories one address per cycle,
// and an evaluate hit then computes the slope product, one multiplier bit per cycle
// with a compare and subtract against den and 2*den. ready comes back in the cycle
// the result turns valid. the result sits in an output register, so the next word
// is taken while it waits to be read; a word that finishes while that register is
// still full waits for it.
// configuration writes (knot_count at index 0, miss value at index 1) are taken
// on any cycle with cfg_we_i high and must only happen while the block is idle.
module piecewise_linear_table_interp_top #(
  parameter int MAX_KNOTS   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [plti_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [VALUE_WIDTH-1:0]         cfg_wdata_i,
  plti_item_if.sink                      item_i,
  plti_result_if.source                  result_o
);

  // command and status between sequencer and datapath
  plti_pkg::cmd_t cmd;
  plti_pkg::sts_t sts;
  logic           in_ready;

  plti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // ready only in idle: one word is worked on at a time
  assign item_i.ready = in_ready;

  plti_dp #(
    .MAX_KNOTS   (MAX_KNOTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .kind_i      (item_i.kind),
    .slot_i      (item_i.slot),
    .arg_i       (item_i.arg),
    .knot_y_i    (item_i.knot_y),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .out_value_o (result_o.value),
    .out_hit_o   (result_o.hit),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for the piecewise linear table interpolator, random and directed words
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW          = 32;
  localparam int KNOTS       = 64;
  localparam int SW          = plti_pkg::SLOT_W;
  localparam int PHASES      = 28;
  localparam int QUERIES     = 38;    // query words per phase, after the table is built
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off to back the block up
  localparam int QUIET_LIMIT = 4000;  // cycles with no word moving before we give up
  localparam int TAIL_CYCLES = 150;
  localparam int MAX_REPORTS = 40;
  localparam int VMIN        = 32'sh8000_0000;
  localparam int VMAX        = 32'sh7fff_ffff;

  typedef struct {
    logic [VW-1:0] value;
    logic          hit;
  } lookup_t;

  // mirrors the knot table and registers, keeps the results still owed by the block
  class knot_table_checker;
    logic signed [VW-1:0]        knot_x [KNOTS];
    logic signed [VW-1:0]        knot_y [KNOTS];
    logic [plti_pkg::KCNT_W-1:0] knot_count;
    logic [VW-1:0]               miss_value;
    lookup_t                     awaited [$];
    int                          failures;

    function new();
      knot_count = '0;
      miss_value = '0;
      failures   = 0;
      foreach (knot_x[i]) begin
        knot_x[i] = '0;
        knot_y[i] = '0;
      end
    endfunction

    function void write_reg(plti_pkg::cfg_idx_e idx, logic [VW-1:0] data);
      if (idx == plti_pkg::CFG_KNOT_COUNT) begin
        knot_count = data[plti_pkg::KCNT_W-1:0];
      end else begin
        miss_value = data;
      end
    endfunction

    function int unsigned knots_used();
      return (knot_count > KNOTS) ? KNOTS : knot_count;
    endfunction

    // first segment with x_i <= x < x_i+1, slope product truncated toward zero
    function lookup_t interp_at(logic signed [VW-1:0] x);
      lookup_t       r;
      int unsigned   n, i;
      longint        x0, x1, y0, y1, dy;
      logic [63:0]   mag, span, offs;
      logic [127:0]  prod;
      logic [VW-1:0] q;
      r.value = miss_value;
      r.hit   = 1'b0;
      n = knots_used();
      if (n == 0) return r;
      if (x < knot_x[0] || x > knot_x[n-1]) return r;
      for (i = 0; i + 1 < n; i++) begin
        x0 = knot_x[i];
        x1 = knot_x[i+1];
        if (x0 <= x && x1 > x) begin
          y0   = knot_y[i];
          y1   = knot_y[i+1];
          dy   = y1 - y0;
          mag  = (dy < 0) ? -dy : dy;
          span = x1 - x0;
          offs = longint'(x) - x0;
          prod = ({64'd0, mag} * {64'd0, offs}) / {64'd0, span};
          q    = prod[VW-1:0];
          r.value = (dy < 0) ? knot_y[i] - q : knot_y[i] + q;
          r.hit   = 1'b1;
          return r;
        end
      end
      return r;
    endfunction

    // lower x of the first segment with y_i <= y < y_i+1, else last knot x
    function lookup_t lower_knot_for(logic signed [VW-1:0] y);
      lookup_t     r;
      int unsigned n, i;
      r.value = '0;
      r.hit   = 1'b0;
      n = knots_used();
      if (n != 0) begin
        r.value = knot_x[n-1];
        for (i = 0; i + 1 < n; i++) begin
          if (knot_y[i] <= y && knot_y[i+1] > y) begin
            r.value = knot_x[i];
            r.hit   = 1'b1;
            break;
          end
        end
      end
      return r;
    endfunction

    function void take_word(plti_pkg::kind_e k, logic [SW-1:0] slot,
                            logic signed [VW-1:0] arg, logic signed [VW-1:0] ky);
      lookup_t r;
      r.value = '0;
      r.hit   = 1'b0;
      case (k)
        plti_pkg::KIND_LOAD: begin
          knot_x[slot] = arg;
          knot_y[slot] = ky;
        end
        plti_pkg::KIND_EVAL: r = interp_at(arg);
        plti_pkg::KIND_INV:  r = lower_knot_for(arg);
        default:   ;
      endcase
      awaited.insert(awaited.size(), r);
    endfunction

    function void check_lookup(logic [VW-1:0] value, logic hit);
      lookup_t e;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t ns: result word with nothing expected: value %h hit %0b",
                   $time, value, hit);
        return;
      end
      e = awaited.pop_front();
      if (value !== e.value || hit !== e.hit) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t ns: mismatch: expected value %h hit %0b, got value %h hit %0b",
                   $time, e.value, e.hit, value, hit);
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                           cfg_we_i;
  logic [plti_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [VW-1:0]                  cfg_wdata_i;

  plti_item_if   #(.VALUE_WIDTH(VW)) item_bus ();
  plti_result_if #(.VALUE_WIDTH(VW)) result_bus ();

  piecewise_linear_table_interp_top #(
    .MAX_KNOTS  (KNOTS),
    .VALUE_WIDTH(VW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (item_bus),
    .result_o   (result_bus)
  );

  knot_table_checker lookups;

  // stimulus-side copy of the table, used only to aim queries at the knots
  int tab_x [KNOTS];
  int tab_y [KNOTS];
  int eff_knots = 0;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  always #4 clk_i = ~clk_i;

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // result checking and the watchdog on cycles where no word moves
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_bus.valid && result_bus.ready)
        lookups.check_lookup(result_bus.value, result_bus.hit);
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("tb: FAIL");
          $finish;
        end
      end
    end
  end

  // offer one word, with random sender gaps; valid stays high after the accept
  // so back-to-back words never lower and raise it in the same step
  task automatic send_word(plti_pkg::kind_e k, logic [SW-1:0] s, logic [VW-1:0] a,
                           logic [VW-1:0] ky);
    while ($urandom_range(99) < src_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_bus.valid  <= 1'b1;
    item_bus.kind   <= k;
    item_bus.slot   <= s;
    item_bus.arg    <= a;
    item_bus.knot_y <= ky;
    do @(posedge clk_i); while (!item_bus.ready);
    lookups.take_word(k, s, a, ky);
  endtask

  // stop offering and wait until every owed result word has been read
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    while (lookups.outstanding() != 0) @(posedge clk_i);
  endtask

  // both registers, only ever called with the block idle
  task automatic write_config(int unsigned count, logic [VW-1:0] dflt);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= plti_pkg::CFG_KNOT_COUNT;
    cfg_wdata_i <= count;
    lookups.write_reg(plti_pkg::CFG_KNOT_COUNT, count);
    @(posedge clk_i);
    cfg_idx_i   <= plti_pkg::CFG_MISS_VALUE;
    cfg_wdata_i <= dflt;
    lookups.write_reg(plti_pkg::CFG_MISS_VALUE, dflt);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // query point: inside a segment, on a knot, next to one, an extreme, or anything
  function automatic int pick_point(bit on_x);
    int     sel, i, k, nxt;
    longint span;
    sel = $urandom_range(99);
    if (eff_knots == 0 || sel >= 80) return $urandom;
    i = $urandom_range(eff_knots - 1);
    k = on_x ? tab_x[i] : tab_y[i];
    if (sel < 40 && i + 1 < eff_knots) begin
      nxt  = on_x ? tab_x[i+1] : tab_y[i+1];
      span = longint'(nxt) - longint'(k);
      if (span > 0) return int'(longint'(k) + (longint'($urandom) % span));
    end
    if (sel < 60) return k;
    if (sel < 70) return $urandom_range(1) ? k + 1 : k - 1;
    case (sel % 4)
      0:       return VMIN;
      1:       return VMAX;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  // load knots 0..n-1: mostly sorted x so evaluates hit, sometimes an unsorted mess
  task automatic build_table(int n);
    int xs [$];
    int ys [$];
    int xshape, yshape, xacc, yacc, i;
    xshape = $urandom_range(9);
    yshape = $urandom_range(2);
    xacc   = int'($urandom) >>> 1;
    yacc   = int'($urandom) >>> 1;
    for (i = 0; i < n; i++) begin
      if (xshape >= 4 && xshape <= 7) begin
        // narrow table, short segments down to one lsb
        xs.insert(xs.size(), xacc);
        xacc += ($urandom_range(3) == 0) ? 1 : $urandom_range(1, 65536);
      end else begin
        xs.insert(xs.size(), int'($urandom));
      end
      if (yshape == 2) begin
        ys.insert(ys.size(), yacc);
        yacc += int'($urandom_range(0, 1 << 20)) - (1 << 18);
      end else begin
        ys.insert(ys.size(), int'($urandom));
      end
    end
    if (xshape < 4) xs.sort();
    if (yshape == 1) ys.sort();
    for (i = 0; i < n; i++) begin
      tab_x[i] = xs[i];
      tab_y[i] = ys[i];
      send_word(plti_pkg::KIND_LOAD, i[SW-1:0], xs[i], ys[i]);
    end
  endtask

  task automatic send_query();
    int sel, s;
    sel = $urandom_range(99);
    if (sel < 45) begin
      send_word(plti_pkg::KIND_EVAL, SW'($urandom_range(KNOTS - 1)), pick_point(1'b1),
                $urandom);
    end else if (sel < 85) begin
      send_word(plti_pkg::KIND_INV, SW'($urandom_range(KNOTS - 1)), pick_point(1'b0),
                $urandom);
    end else if (sel < 93) begin
      // reload a knot in the middle of the queries, any slot
      s = $urandom_range(KNOTS - 1);
      tab_x[s] = $urandom;
      tab_y[s] = $urandom;
      send_word(plti_pkg::KIND_LOAD, s[SW-1:0], tab_x[s], tab_y[s]);
    end else begin
      send_word(plti_pkg::KIND_NONE, SW'($urandom_range(KNOTS - 1)), $urandom, $urandom);
    end
  endtask

  initial begin
    int ph, q, n;
    logic [VW-1:0] dflt;
    lookups = new();
    item_bus.valid   = 1'b0;
    item_bus.kind    = plti_pkg::KIND_LOAD;
    item_bus.slot    = '0;
    item_bus.arg     = '0;
    item_bus.knot_y  = '0;
    result_bus.ready = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = plti_pkg::CFG_KNOT_COUNT;
    cfg_wdata_i      = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table: evaluate falls back to the miss value, inverse gives 0, unknown kind
    send_word(plti_pkg::KIND_EVAL, 6'd0, 32'd0, 32'd0);
    send_word(plti_pkg::KIND_INV, 6'd0, 32'd0, 32'd0);
    send_word(plti_pkg::KIND_NONE, 6'd63, 32'hffff_ffff, 32'hffff_ffff);

    // four knots spanning the whole x range, steep falling first segment
    send_word(plti_pkg::KIND_LOAD, 6'd0, VMIN, VMAX);
    send_word(plti_pkg::KIND_LOAD, 6'd1, 32'hffff_ffff, VMIN);
    send_word(plti_pkg::KIND_LOAD, 6'd2, 32'd0, 32'h0001_0000);
    send_word(plti_pkg::KIND_LOAD, 6'd3, VMAX, 32'h0002_0000);
    send_word(plti_pkg::KIND_LOAD, 6'd63, 32'hffff_ffff, 32'hffff_ffff);
    drain_results();
    write_config(4, VMIN);

    send_word(plti_pkg::KIND_EVAL, 6'd0, VMIN, 32'd0);          // on the first knot
    send_word(plti_pkg::KIND_EVAL, 6'd0, 32'hffff_fffe, 32'd0); // widest slope product
    send_word(plti_pkg::KIND_EVAL, 6'd0, 32'hffff_ffff, 32'd0); // on an inner knot
    send_word(plti_pkg::KIND_EVAL, 6'd0, VMAX - 1, 32'd0);
    send_word(plti_pkg::KIND_EVAL, 6'd0, VMAX, 32'd0);          // on the last knot: miss
    send_word(plti_pkg::KIND_INV, 6'd0, VMIN, 32'd0);
    send_word(plti_pkg::KIND_INV, 6'd0, 32'h0001_8000, 32'd0);
    send_word(plti_pkg::KIND_INV, 6'd0, 32'h0002_0000, 32'd0);  // no segment: last knot x
    drain_results();

    // single knot: no segment at all
    write_config(1, 32'h1234_5678);
    send_word(plti_pkg::KIND_EVAL, 6'd0, VMIN, 32'd0);
    send_word(plti_pkg::KIND_INV, 6'd0, 32'd0, 32'd0);

    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 82; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 82; end
        default: begin src_idle_pct = 9; sink_stall_pct = 9; end
      endcase
      // knot counts sweep empty, one, two, full and saturated
      case (ph % 7)
        0: n = KNOTS;
        1: n = $urandom_range(2, 8);
        2: n = $urandom_range(9, 16);
        3: n = ph % 2;
        4: n = (ph == 4) ? 127 : $urandom_range(KNOTS + 1, 127);
        5: n = 2;
        default: n = $urandom_range(17, 32);
      endcase
      case (ph % 3)
        0: dflt = VMIN;
        1: dflt = VMAX;
        default: dflt = $urandom;
      endcase
      write_config(n, dflt);
      eff_knots = (n > KNOTS) ? KNOTS : n;
      build_table(eff_knots);
      // block fills up and stalls its input while the receiver holds off
      if (ph == 5) hold_req = 1'b1;
      for (q = 0; q < QUERIES; q++) begin
        if (ph == 9 && q == QUERIES / 2) drain_results();
        send_query();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (lookups.failures == 0 && lookups.outstanding() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
